FILE: rtl/anbs_pkg.sv
`default_nettype none

package anbs_pkg;

  localparam int OFFSET_BITS_DEFAULT = 24;

  // Port field widths
  localparam int BYTE_W   = 8;
  localparam int ID_W     = 8;
  localparam int ACC_W    = 9;
  localparam int LIMIT_W  = 9;
  localparam int OFFSET_W = 24;
  localparam int LENGTH_W = 25;
  localparam int CFG_INDEX_W = 1;

  // Config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SEQ_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIC_LIMIT = 1'd1;

  localparam logic [LIMIT_W-1:0] SEQ_LIMIT_RESET = 9'd32;
  localparam logic [LIMIT_W-1:0] PIC_LIMIT_RESET = 9'd256;

  // NAL header
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;

  // Unit kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_SEQ   = 2'd1;
  localparam logic [1:0] KIND_PIC   = 2'd2;

  // Exp-Golomb decoder phases
  localparam logic [1:0] GPH_ZEROS  = 2'd0;
  localparam logic [1:0] GPH_SUFFIX = 2'd1;
  localparam logic [1:0] GPH_DONE   = 2'd2;
  localparam logic [1:0] GPH_FAIL   = 2'd3;

  localparam logic [3:0] MAX_LEADING_ZEROS = 4'd8;

  typedef struct packed {
    logic [1:0]       phase;
    logic [3:0]       leading_zeros;
    logic [3:0]       suffix_left;
    logic [ACC_W-1:0] id_accum;
  } golomb_t;

  typedef struct packed {
    logic                set_kind;
    logic [ID_W-1:0]     set_id;
    logic [OFFSET_W-1:0] unit_offset;
    logic [LENGTH_W-1:0] unit_length;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/anbs_if.sv
`default_nettype none

interface anbs_packet_if;
  logic                         valid;
  logic                         ready;
  logic [anbs_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_in_packet;

  modport source(output valid, output data_byte, output last_in_packet, input ready);
  modport sink(input valid, input data_byte, input last_in_packet, output ready);
endinterface

interface anbs_result_if;
  logic                          valid;
  logic                          ready;
  logic                          set_kind;
  logic [anbs_pkg::ID_W-1:0]     set_id;
  logic [anbs_pkg::OFFSET_W-1:0] unit_offset;
  logic [anbs_pkg::LENGTH_W-1:0] unit_length;

  modport source(output valid, output set_kind, output set_id, output unit_offset,
                 output unit_length, input ready);
  modport sink(input valid, input set_kind, input set_id, input unit_offset,
               input unit_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/anbs_golomb.sv
`default_nettype none

// One byte of ue(v) decoding, MSB first; stops at done or fail.
module anbs_golomb (
  input  wire logic [anbs_pkg::BYTE_W-1:0] data_byte,
  input  wire anbs_pkg::golomb_t           state_in,
  output anbs_pkg::golomb_t                state_out,
  output logic                             done
);

  always_comb begin
    anbs_pkg::golomb_t g;
    logic stop;
    logic b;
    g    = state_in;
    stop = 1'b0;
    done = 1'b0;
    b    = 1'b0;
    for (int i = anbs_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (!stop) begin
        b = data_byte[i];
        case (g.phase)
          anbs_pkg::GPH_ZEROS: begin
            if (!b) begin
              g.leading_zeros = g.leading_zeros + 4'd1;
              if (g.leading_zeros > anbs_pkg::MAX_LEADING_ZEROS) begin
                g.phase = anbs_pkg::GPH_FAIL;
                stop    = 1'b1;
              end
            end else if (g.leading_zeros == 4'd0) begin
              g.id_accum = '0;
              g.phase    = anbs_pkg::GPH_DONE;
              done       = 1'b1;
              stop       = 1'b1;
            end else begin
              g.phase       = anbs_pkg::GPH_SUFFIX;
              g.suffix_left = g.leading_zeros;
              g.id_accum    = '0;
            end
          end
          anbs_pkg::GPH_SUFFIX: begin
            g.id_accum    = {g.id_accum[anbs_pkg::ACC_W-2:0], b};
            g.suffix_left = g.suffix_left - 4'd1;
            if (g.suffix_left == 4'd0) begin
              g.id_accum = ((9'd1 << g.leading_zeros) - 9'd1) + g.id_accum;
              g.phase    = anbs_pkg::GPH_DONE;
              done       = 1'b1;
              stop       = 1'b1;
            end
          end
          default: begin
            stop = 1'b1;
          end
        endcase
      end
    end
    state_out = g;
  end

endmodule

`default_nettype wire

FILE: rtl/anbs_core.sv
`default_nettype none

// Per-byte scanner state: start code match, header tracking, unit close.
module anbs_core #(
  parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire logic [anbs_pkg::BYTE_W-1:0]        data_byte,
  input  wire logic                               last_in_packet,
  input  wire logic                               cfg_write,
  input  wire logic [anbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [anbs_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                                    res_valid,
  output anbs_pkg::result_t                       res
);

  localparam int OB = OFFSET_BITS;

  logic [anbs_pkg::LIMIT_W-1:0] seq_limit, pic_limit;

  logic [1:0]    zero_run, zero_run_next;
  logic [OB-1:0] byte_position, byte_position_next;
  logic          unit_open, unit_open_next;
  logic [OB-1:0] unit_start, unit_start_next;
  logic [1:0]    unit_kind, unit_kind_next;
  logic [2:0]    header_bytes_seen, header_bytes_seen_next;
  anbs_pkg::golomb_t gst, gst_next, gst_step;
  logic          golomb_done;
  logic          id_ready, id_ready_next;
  logic [1:0]    ready_age, ready_age_next;

  logic          sc_hit;
  logic [OB-1:0] sc_pos;
  logic          closing;
  logic [1:0]    close_kind;
  logic [anbs_pkg::ACC_W-1:0] close_acc;
  logic          close_ok;
  logic [OB:0]   close_len;
  logic [anbs_pkg::LIMIT_W-1:0] close_limit;
  logic [OB+anbs_pkg::LENGTH_W:0]   len_wide;
  logic [OB+anbs_pkg::OFFSET_W-1:0] off_wide;

  anbs_golomb u_golomb (
    .data_byte (data_byte),
    .state_in  (gst),
    .state_out (gst_step),
    .done      (golomb_done)
  );

  always_comb begin
    zero_run_next          = zero_run;
    byte_position_next     = byte_position;
    unit_open_next         = unit_open;
    unit_start_next        = unit_start;
    unit_kind_next         = unit_kind;
    header_bytes_seen_next = header_bytes_seen;
    gst_next               = gst;
    id_ready_next          = id_ready;
    ready_age_next         = ready_age;

    sc_hit = (zero_run == 2'd3) && (data_byte == 8'd1) && !last_in_packet;
    sc_pos = byte_position - OB'(3);

    closing    = 1'b0;
    close_kind = unit_kind;
    close_acc  = gst.id_accum;
    close_ok   = 1'b0;
    close_len  = '0;

    if (sc_hit) begin
      closing    = unit_open;
      close_ok   = id_ready && (ready_age == 2'd3);
      close_len  = {1'b0, sc_pos - unit_start};
      unit_open_next  = 1'b1;
      unit_start_next = sc_pos;
      zero_run_next   = 2'd0;
    end else begin
      if (data_byte == 8'd0) begin
        zero_run_next = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
      end else begin
        zero_run_next = 2'd0;
      end
      if (unit_open) begin
        if (id_ready && (ready_age != 2'd3)) begin
          ready_age_next = ready_age + 2'd1;
        end
        if (header_bytes_seen == 3'd0) begin
          if ((data_byte[4:0] & anbs_pkg::NAL_TYPE_MASK) == anbs_pkg::NAL_TYPE_SPS) begin
            unit_kind_next = anbs_pkg::KIND_SEQ;
          end else if ((data_byte[4:0] & anbs_pkg::NAL_TYPE_MASK) == anbs_pkg::NAL_TYPE_PPS) begin
            unit_kind_next = anbs_pkg::KIND_PIC;
          end else begin
            unit_kind_next = anbs_pkg::KIND_OTHER;
          end
        end else if ((unit_kind != anbs_pkg::KIND_OTHER) && !gst.phase[1] &&
                     (header_bytes_seen >=
                      ((unit_kind == anbs_pkg::KIND_SEQ) ? 3'd4 : 3'd1))) begin
          gst_next = gst_step;
          if (golomb_done) begin
            id_ready_next  = 1'b1;
            ready_age_next = 2'd0;
          end
        end
        if (header_bytes_seen != 3'd7) begin
          header_bytes_seen_next = header_bytes_seen + 3'd1;
        end
        closing    = last_in_packet;
        close_kind = unit_kind_next;
        close_acc  = gst_next.id_accum;
        close_ok   = id_ready_next;
        close_len  = {1'b0, byte_position - unit_start} + {{OB{1'b0}}, 1'b1};
      end
    end

    // new unit or end of packet: drop all per-unit state
    if (sc_hit || last_in_packet) begin
      unit_kind_next         = anbs_pkg::KIND_OTHER;
      header_bytes_seen_next = 3'd0;
      gst_next               = '0;
      id_ready_next          = 1'b0;
      ready_age_next         = 2'd0;
    end
    if (last_in_packet) begin
      zero_run_next      = 2'd0;
      byte_position_next = '0;
      unit_open_next     = 1'b0;
      unit_start_next    = '0;
    end else begin
      byte_position_next = byte_position + OB'(1);
    end

    close_limit = (close_kind == anbs_pkg::KIND_SEQ) ? seq_limit : pic_limit;
    res_valid = fire && closing && (close_kind != anbs_pkg::KIND_OTHER) && close_ok &&
                !close_acc[anbs_pkg::ACC_W-1] && (close_acc < close_limit);

    len_wide = {{anbs_pkg::LENGTH_W{1'b0}}, close_len};
    off_wide = {{anbs_pkg::OFFSET_W{1'b0}}, unit_start};
    res.set_kind    = (close_kind == anbs_pkg::KIND_PIC);
    res.set_id      = close_acc[anbs_pkg::ID_W-1:0];
    res.unit_offset = off_wide[anbs_pkg::OFFSET_W-1:0];
    res.unit_length = len_wide[anbs_pkg::LENGTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_limit <= anbs_pkg::SEQ_LIMIT_RESET;
      pic_limit <= anbs_pkg::PIC_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        anbs_pkg::CFG_SEQ_LIMIT: seq_limit <= cfg_data;
        anbs_pkg::CFG_PIC_LIMIT: pic_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run          <= 2'd0;
      byte_position     <= '0;
      unit_open         <= 1'b0;
      unit_start        <= '0;
      unit_kind         <= anbs_pkg::KIND_OTHER;
      header_bytes_seen <= 3'd0;
      gst               <= '0;
      id_ready          <= 1'b0;
      ready_age         <= 2'd0;
    end else if (fire) begin
      zero_run          <= zero_run_next;
      byte_position     <= byte_position_next;
      unit_open         <= unit_open_next;
      unit_start        <= unit_start_next;
      unit_kind         <= unit_kind_next;
      header_bytes_seen <= header_bytes_seen_next;
      gst               <= gst_next;
      id_ready          <= id_ready_next;
      ready_age         <= ready_age_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/anbs_out_fifo.sv
`default_nettype none

// Two-entry result buffer; decouples input acceptance from output stalls.
module anbs_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire anbs_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output anbs_pkg::result_t      out_data
);

  anbs_pkg::result_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/annexb_sps_pps_nal_scanner.sv
// Annex B parameter set scanner. Takes one packet byte per transaction on
// packet and finds 00 00 00 01 start codes; for sequence (type 7) and picture
// (type 8) parameter sets it decodes the ue(v) id and, when the unit closes
// (next start code or last byte of the packet), emits one result transaction
// with kind, id, start-code offset and length, if the id is below the limit
// set in cfg register 0 (sequence) or 1 (picture). One byte is accepted every
// clock cycle; the whole per-byte update is combinational logic around the
// scanner state registers, and results go through a two-entry output buffer,
// so packet.ready drops only while both buffer entries are waiting on result.
// Results are registered in the output buffer before they appear on result.
`default_nettype none

module annexb_sps_pps_nal_scanner #(
  parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  anbs_packet_if.sink                           packet,
  anbs_result_if.source                         result,
  input  wire logic                             cfg_write,
  input  wire logic [anbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [anbs_pkg::LIMIT_W-1:0]     cfg_data
);

  logic              fire;
  logic              res_valid;
  anbs_pkg::result_t res;
  anbs_pkg::result_t out_data;
  logic              buf_full;

  // byte accepted whenever the result buffer has room
  assign packet.ready = !buf_full;
  assign fire         = packet.valid && packet.ready;

  anbs_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .data_byte      (packet.data_byte),
    .last_in_packet (packet.last_in_packet),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .res_valid      (res_valid),
    .res            (res)
  );

  anbs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.set_kind    = out_data.set_kind;
  assign result.set_id      = out_data.set_id;
  assign result.unit_offset = out_data.unit_offset;
  assign result.unit_length = out_data.unit_length;

endmodule

`default_nettype wire
